// ----- hw/rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, codes and defaults for the stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int SFR_BUFFER_BYTES = 256;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_START_CODE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_END_CODE    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd2;

  localparam logic [7:0] START_CODE_RST  = 8'd2;
  localparam logic [7:0] END_CODE_RST    = 8'd3;
  localparam logic [7:0] ESCAPE_CODE_RST = 8'd16;

  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_ESC    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [8:0] frame_length;
  } res_t;

endpackage

// ----- hw/rtl/sfr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Holds the start, end and escape code registers written over the config port.
// ----------------------------------------------------------------------------
module sfr_cfg_regs
  import sfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_START_CODE:  cfg_nxt.start_code  = cfg_data;
        REG_END_CODE:    cfg_nxt.end_code    = cfg_data;
        REG_ESCAPE_CODE: cfg_nxt.escape_code = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code  <= START_CODE_RST;
      cfg_r.end_code    <= END_CODE_RST;
      cfg_r.escape_code <= ESCAPE_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hw/rtl/sfr_deframer.sv -----
// ----------------------------------------------------------------------------
// sfr_deframer
// Frame state machine: unstuffs bytes, tracks length and checksum, and
// produces at most one result for each byte it is given.
// ----------------------------------------------------------------------------
module sfr_deframer
  import sfr_pkg::*;
#(
  parameter int BUFFER_BYTES = SFR_BUFFER_BYTES
)(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       fire,
  input  logic [7:0] ch,
  output logic       res_vld,
  output res_t       res
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

  mode_t             mode_r, mode_nxt, mode_cur;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_cur;
  logic [15:0]       len_r, len_nxt, len_upd;
  logic [7:0]        xor_r, xor_nxt;
  logic [15:0]       chk_r, chk_nxt;
  logic [16:0]       cnt_ext;
  logic [16:0]       lim;
  logic [7:0]        b;
  logic              good;

  always_comb begin
    mode_cur = mode_r;
    cnt_cur  = cnt_r;
    if (cnt_r >= CNT_W'(BUFFER_BYTES)) begin
      mode_cur = MODE_IDLE;
      cnt_cur  = '0;
    end
    cnt_ext  = 17'(cnt_cur);
    b        = (mode_cur == MODE_ESC) ? (ch ^ cfg.escape_code) : ch;
    len_upd  = len_r;
    if (cnt_cur == '0) begin
      len_upd[7:0] = b;
    end else if (cnt_cur == CNT_W'(1)) begin
      len_upd[15:8] = b;
    end
    lim  = {1'b0, len_upd} + 17'd2;
    good = (cnt_ext >= ({1'b0, len_r} + 17'd4)) && (chk_r == {8'h00, xor_r});

    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    xor_nxt  = xor_r;
    chk_nxt  = chk_r;
    res_vld  = 1'b0;
    res      = '{kind: KIND_DATA, data_byte: 8'h00, byte_index: 8'h00, frame_length: 9'h000};

    if (fire) begin
      mode_nxt = mode_cur;
      cnt_nxt  = cnt_cur;
      if (ch == cfg.start_code) begin
        mode_nxt = MODE_ACTIVE;
        cnt_nxt  = '0;
        len_nxt  = '0;
        xor_nxt  = '0;
        chk_nxt  = '0;
      end else if (ch == cfg.end_code) begin
        if (mode_cur == MODE_ACTIVE) begin
          mode_nxt         = MODE_IDLE;
          res_vld          = 1'b1;
          res.kind         = good ? KIND_GOOD : KIND_BAD;
          res.frame_length = cnt_ext[8:0];
        end
      end else if (ch == cfg.escape_code) begin
        if (mode_cur != MODE_IDLE) begin
          mode_nxt = MODE_ESC;
        end
      end else if (mode_cur != MODE_IDLE) begin
        mode_nxt = MODE_ACTIVE;
        len_nxt  = len_upd;
        if (cnt_ext < lim) begin
          xor_nxt = xor_r ^ b;
        end else if (cnt_ext == lim) begin
          chk_nxt[7:0] = b;
        end else if (cnt_ext == lim + 17'd1) begin
          chk_nxt[15:8] = b;
        end
        cnt_nxt        = cnt_cur + CNT_W'(1);
        res_vld        = 1'b1;
        res.data_byte  = b;
        res.byte_index = cnt_ext[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
      len_r  <= '0;
      xor_r  <= '0;
      chk_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      len_r  <= len_nxt;
      xor_r  <= xor_nxt;
      chk_r  <= chk_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BUFFER_BYTES))
    else $error("stored count beyond buffer size");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(cnt_r) && $stable(mode_r) && $stable(xor_r))
    else $error("frame state changed without an item");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (ch == cfg.start_code) |=> (mode_r == MODE_ACTIVE) && (cnt_r == '0))
    else $error("start code did not open a fresh frame");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && (res.kind != KIND_DATA) |=> (mode_r == MODE_IDLE))
    else $error("frame end report without return to idle");

endmodule

// ----- hw/rtl/stuffed_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_core
// Byte-stuffed frame receiver with start, end and escape codes and checksum.
// ----------------------------------------------------------------------------
// One received byte is taken every clock cycle unless the output stalls.
// Each byte passes an input register, the combinational frame state update,
// and a result register that presents its result. The result register
// decouples the sides: input is stalled only while a result waits unread and
// a byte is already held. Each data byte is given out with its index, and an
// end code inside an active frame gives a good or bad report with the number
// of stored bytes.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_core
  import sfr_pkg::*;
#(
  parameter int BUFFER_BYTES = SFR_BUFFER_BYTES
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] data_byte, [15:8] byte_index,
                                             // [24:16] frame_length, [31:25] zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [1:0] kind
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]             cfg_data
);

  cfg_t       cfg;
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       adv;
  logic       fire;
  logic       res_vld;
  res_t       res;
  logic       out_vld_r;
  res_t       out_res_r;

  sfr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;
  assign fire      = in_vld_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  sfr_deframer #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (fire),
    .ch      (in_byte_r),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fire && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {7'b0, out_res_r.frame_length, out_res_r.byte_index,
                       out_res_r.data_byte};

endmodule
